[hdl/spgm_pkg.sv]
// Shared types and constants for the sample paste gain mixer.
`default_nettype none

package spgm_pkg;

  // Gain format: unsigned Q4.GAIN_FRAC_BITS.
  localparam int GAIN_FRAC_BITS = 20;
  localparam int GAIN_W         = 24;
  localparam int SAMPLE_W       = 16;

  // Doubled source sample (sum of left and right) and the two products.
  localparam int SSUM_W  = SAMPLE_W + 1;
  localparam int PROD_SW = SSUM_W + GAIN_W + 1;
  localparam int PROD_DW = SAMPLE_W + GAIN_W + 1;

  // Sample scale exponents: full scale is 2^7 or 2^15.
  localparam int SCALE_8  = 7;
  localparam int SCALE_16 = 15;

  // Exact mixed sum and its rounded form.
  localparam int SUM_W = PROD_SW + SCALE_16 + 1;
  localparam int RND_W = SUM_W + 1;
  // Width that holds the clip limits at the largest scale.
  localparam int LIM_W = 2 * SCALE_16 + GAIN_FRAC_BITS + 3;
  localparam int CMP_W = (SUM_W > LIM_W) ? SUM_W : LIM_W;
  localparam int SHIFT_W = $clog2(2 * SCALE_16 + GAIN_FRAC_BITS + 2);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_IS_16BIT = 3'd0,
    REG_DEST_IS_16BIT   = 3'd1,
    REG_DEST_STEREO     = 3'd2,
    REG_CHANNEL_CHOICE  = 3'd3,
    REG_MIX_MODE        = 3'd4,
    REG_SOURCE_GAIN     = 3'd5,
    REG_DEST_GAIN       = 3'd6
  } cfg_reg_t;

  // Channel choice codes; the unused code behaves as right only.
  localparam logic [1:0] CH_BOTH  = 2'd0;
  localparam logic [1:0] CH_LEFT  = 2'd1;
  localparam logic [1:0] CH_RIGHT = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] source_left;
    logic signed [SAMPLE_W-1:0] source_right;
    logic signed [SAMPLE_W-1:0] dest_left;
    logic signed [SAMPLE_W-1:0] dest_right;
    logic                       dest_present;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       left_clipped;
    logic                       right_clipped;
  } out_item_t;

  // Stage enables and static width settings for one channel lane.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic src16;
    logic dst16;
  } lane_ctl_t;

endpackage

`default_nettype wire

[hdl/spgm_lane.sv]
// One channel of the mixer: gain products, exact sum, clip test and rounding.
`default_nettype none

module spgm_lane import spgm_pkg::*; (
  input  logic                        clk,
  input  lane_ctl_t                   ctl,
  input  logic signed [SSUM_W-1:0]    ssum,
  input  logic signed [SAMPLE_W-1:0]  dest,
  input  logic [GAIN_W-1:0]           source_gain,
  input  logic [GAIN_W-1:0]           dest_gain,
  output logic signed [SAMPLE_W-1:0]  value,
  output logic                        clipped
);

  logic signed [PROD_SW-1:0] prod_s;
  logic signed [PROD_DW-1:0] prod_d;
  logic signed [SUM_W-1:0]   num;
  logic signed [SUM_W-1:0]   num_next;
  logic signed [RND_W-1:0]   rsum;
  logic signed [RND_W-1:0]   rsum_next;
  logic                      clip_hi;
  logic                      clip_lo;
  logic                      clip_hi_next;
  logic                      clip_lo_next;
  logic [SHIFT_W-1:0]        sh_e;
  logic [SHIFT_W-1:0]        sh_lo;
  logic signed [CMP_W-1:0]   num_x;
  logic signed [CMP_W-1:0]   hi_lim;
  logic signed [CMP_W-1:0]   lo_lim;
  logic signed [RND_W-1:0]   half;
  logic signed [RND_W-1:0]   shifted;
  logic signed [SAMPLE_W-1:0] full_m1;

  // Stage 1: the two gain products.
  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      prod_s <= PROD_SW'(ssum) * PROD_SW'($signed({1'b0, source_gain}));
      prod_d <= PROD_DW'(dest) * PROD_DW'($signed({1'b0, dest_gain}));
    end
  end

  // Stage 2: bring both products to the common scale and add.
  always_comb begin
    num_next = (ctl.dst16 ? (SUM_W'(prod_s) <<< SCALE_16) : (SUM_W'(prod_s) <<< SCALE_8))
             + (ctl.src16 ? (SUM_W'(prod_d) <<< (SCALE_16 + 1))
                          : (SUM_W'(prod_d) <<< (SCALE_8 + 1)));
  end

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      num <= num_next;
    end
  end

  // Stage 3: range test against the destination full scale and the rounding add.
  // Rounding half away from zero is a floor shift after adding half, less one
  // for negative sums.
  always_comb begin
    sh_e   = ctl.src16 ? SHIFT_W'(SCALE_16 + 1 + GAIN_FRAC_BITS)
                       : SHIFT_W'(SCALE_8 + 1 + GAIN_FRAC_BITS);
    sh_lo  = sh_e + (ctl.dst16 ? SHIFT_W'(SCALE_16) : SHIFT_W'(SCALE_8));
    num_x  = CMP_W'(num);
    hi_lim = (ctl.dst16 ? CMP_W'((1 << SCALE_16) - 1) : CMP_W'((1 << SCALE_8) - 1)) << sh_e;
    lo_lim = -(CMP_W'(1) << sh_lo);
    clip_hi_next = num_x > hi_lim;
    clip_lo_next = num_x < lo_lim;
    half      = RND_W'(1) << (sh_e - SHIFT_W'(1));
    rsum_next = RND_W'(num) + half - RND_W'(num[SUM_W-1]);
  end

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      rsum    <= rsum_next;
      clip_hi <= clip_hi_next;
      clip_lo <= clip_lo_next;
    end
  end

  // Final shift and clamp, registered by the top level.
  always_comb begin
    shifted = rsum >>> sh_e;
    full_m1 = ctl.dst16 ? SAMPLE_W'((1 << SCALE_16) - 1) : SAMPLE_W'((1 << SCALE_8) - 1);
    if (clip_hi) begin
      value = full_m1;
    end else if (clip_lo) begin
      value = ~full_m1;
    end else begin
      value = shifted[SAMPLE_W-1:0];
    end
    clipped = clip_hi | clip_lo;
  end

endmodule

`default_nettype wire

[hdl/sample_paste_gain_mixer_top.sv]
// Top level of the sample paste gain mixer: register file, control and lanes.
`default_nettype none

// Channel   Handshake            Payload
// in        in_valid / in_stall  in_data   (in_item_t, one frame)
// out       out_valid / out_stall out_data (out_item_t, one frame)
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data (register write)
//
// A frame accepted at the input shows up as a valid result after it has passed
// each stage, and one frame can enter every cycle while in_stall is low. The
// depth is set by the lane pipeline: gain multiply, scaled add, clip test with
// rounding add, then the output register.
// Reset clears the valid bits and loads the register defaults (unity gains,
// 16-bit stereo, both channels, overwrite). A stall on the output holds the
// output register; earlier stages keep moving into empty slots, so bubbles
// are squeezed out before the input is stalled.

module sample_paste_gain_mixer_top import spgm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic              source_is_16bit;
  logic              dest_is_16bit;
  logic              dest_stereo;
  logic [1:0]        channel_choice;
  logic              mix_mode;
  logic [GAIN_W-1:0] source_gain;
  logic [GAIN_W-1:0] dest_gain;

  // Writes are always taken, unchecked; write only into an empty pipeline.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_is_16bit <= 1'b1;
      dest_is_16bit   <= 1'b1;
      dest_stereo     <= 1'b1;
      channel_choice  <= CH_BOTH;
      mix_mode        <= 1'b0;
      source_gain     <= GAIN_W'(1 << GAIN_FRAC_BITS);
      dest_gain       <= GAIN_W'(1 << GAIN_FRAC_BITS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SOURCE_IS_16BIT: source_is_16bit <= cfg_data[0];
        REG_DEST_IS_16BIT:   dest_is_16bit   <= cfg_data[0];
        REG_DEST_STEREO:     dest_stereo     <= cfg_data[0];
        REG_CHANNEL_CHOICE:  channel_choice  <= cfg_data[1:0];
        REG_MIX_MODE:        mix_mode        <= cfg_data[0];
        REG_SOURCE_GAIN:     source_gain     <= cfg_data;
        REG_DEST_GAIN:       dest_gain       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control. Each stage loads when it is empty or when the
  // stage after it is loading, so a stall ripples back only through full
  // stages.
  logic v1, v2, v3;
  logic r1, r2, r3, r_out;

  assign r_out    = !out_valid || !out_stall;
  assign r3       = !v3 || r_out;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_stall = !r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1)    v1        <= in_valid;
      if (r2)    v2        <= v1;
      if (r3)    v3        <= v2;
      if (r_out) out_valid <= v3;
    end
  end

  // Input decode. An 8-bit sample lives in the low byte of its field.
  function automatic logic signed [SAMPLE_W-1:0] fit_width(
    input logic signed [SAMPLE_W-1:0] s,
    input logic                       wide
  );
    logic signed [7:0] narrow;
    narrow = s[7:0];
    return wide ? s : SAMPLE_W'(narrow);
  endfunction

  logic signed [SAMPLE_W-1:0] sl, sr, dl, dr;
  logic                       mono, add_dest, sel_l, sel_r;
  logic signed [SSUM_W-1:0]   ssum_mono, ssum_l, ssum_r;
  logic signed [SAMPLE_W-1:0] mix_l, mix_r, pass_l, pass_r;

  always_comb begin
    sl = fit_width(in_data.source_left,  source_is_16bit);
    sr = fit_width(in_data.source_right, source_is_16bit);
    dl = fit_width(in_data.dest_left,    dest_is_16bit);
    dr = fit_width(in_data.dest_right,   dest_is_16bit);
    // A mono destination or a single written channel takes the mean of the
    // source pair, carried doubled so that it stays exact.
    mono      = !dest_stereo || (channel_choice != CH_BOTH);
    ssum_mono = SSUM_W'(sl) + SSUM_W'(sr);
    ssum_l    = mono ? ssum_mono : (SSUM_W'(sl) <<< 1);
    ssum_r    = mono ? ssum_mono : (SSUM_W'(sr) <<< 1);
    add_dest  = mix_mode && in_data.dest_present;
    mix_l     = add_dest ? dl : '0;
    mix_r     = add_dest ? dr : '0;
    // Left is written for both or left only; right needs a stereo destination
    // and is written for every choice except left only.
    sel_l     = (channel_choice == CH_BOTH) || (channel_choice == CH_LEFT);
    sel_r     = dest_stereo && (channel_choice != CH_LEFT);
    pass_l    = in_data.dest_present ? dl : '0;
    pass_r    = (in_data.dest_present && dest_stereo) ? dr : '0;
  end

  // Side data that rides along with each frame to the output stage.
  typedef struct packed {
    logic                       sel_l;
    logic                       sel_r;
    logic signed [SAMPLE_W-1:0] pass_l;
    logic signed [SAMPLE_W-1:0] pass_r;
  } side_t;

  side_t side1, side2, side3;

  always_ff @(posedge clk) begin
    if (r1) side1 <= '{sel_l: sel_l, sel_r: sel_r, pass_l: pass_l, pass_r: pass_r};
    if (r2) side2 <= side1;
    if (r3) side3 <= side2;
  end

  // Both lanes share the stage enables and the width settings.
  lane_ctl_t lane_ctl;

  assign lane_ctl = '{en1: r1, en2: r2, en3: r3,
                      src16: source_is_16bit, dst16: dest_is_16bit};

  logic signed [SAMPLE_W-1:0] lane_l_value, lane_r_value;
  logic                       lane_l_clip, lane_r_clip;

  spgm_lane u_lane_left (
    .clk         (clk),
    .ctl         (lane_ctl),
    .ssum        (ssum_l),
    .dest        (mix_l),
    .source_gain (source_gain),
    .dest_gain   (dest_gain),
    .value       (lane_l_value),
    .clipped     (lane_l_clip)
  );

  spgm_lane u_lane_right (
    .clk         (clk),
    .ctl         (lane_ctl),
    .ssum        (ssum_r),
    .dest        (mix_r),
    .source_gain (source_gain),
    .dest_gain   (dest_gain),
    .value       (lane_r_value),
    .clipped     (lane_r_clip)
  );

  // Output register: a written channel takes the lane result, an unwritten
  // one keeps the destination sample (zero past its end, or for a mono right).
  always_ff @(posedge clk) begin
    if (r_out) begin
      out_data.out_left      <= side3.sel_l ? lane_l_value : side3.pass_l;
      out_data.out_right     <= side3.sel_r ? lane_r_value : side3.pass_r;
      out_data.left_clipped  <= side3.sel_l && lane_l_clip;
      out_data.right_clipped <= side3.sel_r && lane_r_clip;
    end
  end

endmodule

`default_nettype wire
